// File: rtl/ccbt_pkg.sv
// ----------------------------------------------------------------------------
// ccbt_pkg
// Shared widths, register indexes, constants and divider types for the
// charge counter with breakpoint timer.
// ----------------------------------------------------------------------------
package ccbt_pkg;

   localparam int CHARGE_W  = 33;
   localparam int CURRENT_W = 24;
   localparam int STORE_W   = 32;
   localparam int SOC_W     = 14;
   localparam int MS_W      = 42;
   localparam int NPTS_W    = 3;
   localparam int PROD_W    = STORE_W + SOC_W;
   localparam int STEP_W    = 6;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CAPACITY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_BASE    = 3'd2;

   localparam logic [STORE_W-1:0] CAP_RESET = 32'd7200000;
   localparam logic [SOC_W-1:0]   SOC_FULL  = 14'd10000;

   localparam logic [STEP_W-1:0] SOC_STEPS  = 6'(SOC_W);
   localparam logic [STEP_W-1:0] TIME_STEPS = 6'(PROD_W);

   typedef struct packed {
      logic [STORE_W-1:0] rem;
      logic [PROD_W-1:0]  num;
      logic [STEP_W-1:0]  steps;
      logic [STORE_W-1:0] divisor;
   } ccbt_div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] quotient;
   } ccbt_div_sts_type;

endpackage

// File: rtl/ccbt_req_if.sv
// ----------------------------------------------------------------------------
// ccbt_req_if
// Request channel: one charge update word with the present current.
// ----------------------------------------------------------------------------
interface ccbt_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  op;
   logic signed [ccbt_pkg::CHARGE_W-1:0]  charge;
   logic signed [ccbt_pkg::CURRENT_W-1:0] current;

   modport source (output valid, output op, output charge, output current, input ready);
   modport sink   (input valid, input op, input charge, input current, output ready);
endinterface

// File: rtl/ccbt_rsp_if.sv
// ----------------------------------------------------------------------------
// ccbt_rsp_if
// Response channel: stored charge, state of charge and time to breakpoint.
// ----------------------------------------------------------------------------
interface ccbt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ccbt_pkg::STORE_W-1:0]   stored_charge;
   logic [ccbt_pkg::SOC_W-1:0]     soc_hundredths;
   logic [ccbt_pkg::MS_W-1:0]      time_to_point_ms;
   logic                           no_limit;

   modport source (output valid, output stored_charge, output soc_hundredths,
                   output time_to_point_ms, output no_limit, input ready);
   modport sink   (input valid, input stored_charge, input soc_hundredths,
                   input time_to_point_ms, input no_limit, output ready);
endinterface

// File: rtl/ccbt_div.sv
// ----------------------------------------------------------------------------
// ccbt_div
// Shift-subtract divider, one quotient bit per cycle, preloadable partial
// remainder so that short quotients take only as many steps as their width.
// ----------------------------------------------------------------------------
module ccbt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  ccbt_pkg::ccbt_div_req_type req,
   output ccbt_pkg::ccbt_div_sts_type sts
);
   import ccbt_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [STORE_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0]   num_ff, num_in;
   logic [STORE_W-1:0]  dvs_ff, dvs_in;
   logic [STORE_W:0]    trial;
   logic                ge;

   assign trial = {rem_ff, num_ff[PROD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rem;
         num_in  = req.num;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? STORE_W'(trial - {1'b0, dvs_ff}) : STORE_W'(trial);
         num_in = {num_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = num_ff;

endmodule

// File: rtl/charge_counter_breakpoint_timer.sv
// ----------------------------------------------------------------------------
// charge_counter_breakpoint_timer
// Coulomb counter: clamps the stored charge, derives state of charge and the
// time until the next breakpoint in the direction of the current.
//
//   channel | dir | handshake      | word
//   req     | in  | valid / ready  | op, charge, current
//   rsp     | out | valid / ready  | stored_charge, soc_hundredths,
//           |     |                | time_to_point_ms, no_limit
//   csr     | in  | csr_we         | csr_index, csr_wdata
//
// One word at a time: a new word is accepted only in IDLE. The
// shift-subtract divider runs 14 steps for state of charge and 46 steps
// for the time, and each breakpoint passes a multiply and a compare state
// on the shared multiplier. Synchronous active-high reset. A finished
// result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module charge_counter_breakpoint_timer #(
   parameter int MAX_POINTS = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   ccbt_req_if.sink                       req_bus,
   ccbt_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [ccbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ccbt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ccbt_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   typedef enum logic [3:0] {
      IDLE, SCALE, SOC_RUN, SOC_WAIT, PT_START, PT_MUL, PT_CMP,
      TIME_RUN, TIME_WAIT, FINISH
   } state_type;

   logic [STORE_W-1:0] cap_ff;
   logic [NPTS_W-1:0]  pin_ff;
   logic [SOC_W-1:0]   point_ff [MAX_POINTS];

   state_type                 state_ff, state_in;
   logic [STORE_W-1:0]        store_ff, store_in;
   logic signed [CURRENT_W-1:0] cur_ff, cur_in;
   logic [PROD_W-1:0]         scaled_ff, scaled_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [PROD_W-1:0]         best_ff, best_in;
   logic                      found_ff, found_in;
   logic [SOC_W-1:0]          soc_ff, soc_in;
   logic [MS_W-1:0]           ms_ff, ms_in;
   logic [NPTS_W-1:0]         cnt_ff, cnt_in;
   logic                      div_start_ff, div_start_in;
   ccbt_div_req_type          div_req_ff, div_req_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STORE_W-1:0]        rsp_charge_ff, rsp_charge_in;
   logic [SOC_W-1:0]          rsp_soc_ff, rsp_soc_in;
   logic [MS_W-1:0]           rsp_ms_ff, rsp_ms_in;
   logic                      rsp_nl_ff, rsp_nl_in;

   ccbt_div_sts_type          div_sts;
   logic [NPTS_W-1:0]         n_sat;
   logic [STORE_W-1:0]        mul_a;
   logic [SOC_W-1:0]          mul_b;
   logic [PROD_W-1:0]         mul_out;
   logic signed [CHARGE_W+1:0] sum;
   logic [STORE_W-1:0]        clamped;
   logic [CURRENT_W-1:0]      amag;
   logic [STORE_W-1:0]        cur_x10;
   logic [PROD_W-1:0]         diff;
   logic                      hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         pin_ff <= '0;
         for (int i = 0; i < MAX_POINTS; i++) begin
            point_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_CAPACITY) begin
            cap_ff <= csr_wdata;
         end
         if (csr_index == CSR_POINTS_IN_USE) begin
            pin_ff <= csr_wdata[NPTS_W-1:0];
         end
         for (int i = 0; i < MAX_POINTS; i++) begin
            if (csr_index == CSR_POINT_BASE + CSR_IDX_W'(i)) begin
               point_ff[i] <= csr_wdata[SOC_W-1:0];
            end
         end
      end
   end

   assign n_sat = (pin_ff > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS) : pin_ff;

   // shared multiplier
   always_comb begin
      if (state_ff == PT_MUL) begin
         mul_a = cap_ff;
         mul_b = point_ff[cnt_ff[IDX_W-1:0]];
      end else begin
         mul_a = store_ff;
         mul_b = SOC_FULL;
      end
   end
   assign mul_out = {{SOC_W{1'b0}}, mul_a} * {{STORE_W{1'b0}}, mul_b};

   // clamp of the new charge
   always_comb begin
      sum = {{2{req_bus.charge[CHARGE_W-1]}}, req_bus.charge};
      if (!req_bus.op) begin
         sum = sum + $signed({3'b000, store_ff});
      end
      if (sum[CHARGE_W+1]) begin
         clamped = '0;
      end else if (sum > $signed({3'b000, cap_ff})) begin
         clamped = cap_ff;
      end else begin
         clamped = sum[STORE_W-1:0];
      end
   end

   assign amag    = cur_ff[CURRENT_W-1] ? CURRENT_W'(-cur_ff) : CURRENT_W'(cur_ff);
   assign cur_x10 = STORE_W'({amag, 3'b000}) + STORE_W'({amag, 1'b0});
   assign diff    = (best_ff > scaled_ff) ? best_ff - scaled_ff : scaled_ff - best_ff;
   assign hit     = cur_ff[CURRENT_W-1]
                    ? (prod_ff < scaled_ff) && (!found_ff || prod_ff > best_ff)
                    : (prod_ff > scaled_ff) && (!found_ff || prod_ff < best_ff);

   assign req_bus.ready = (state_ff == IDLE);

   always_comb begin
      state_in      = state_ff;
      store_in      = store_ff;
      cur_in        = cur_ff;
      scaled_in     = scaled_ff;
      prod_in       = prod_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      soc_in        = soc_ff;
      ms_in         = ms_ff;
      cnt_in        = cnt_ff;
      div_start_in  = 1'b0;
      div_req_in    = div_req_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_charge_in = rsp_charge_ff;
      rsp_soc_in    = rsp_soc_ff;
      rsp_ms_in     = rsp_ms_ff;
      rsp_nl_in     = rsp_nl_ff;
      case (state_ff)
         IDLE: begin
            if (req_bus.valid) begin
               store_in = clamped;
               cur_in   = req_bus.current;
               found_in = 1'b0;
               soc_in   = '0;
               ms_in    = '0;
               state_in = SCALE;
            end
         end
         SCALE: begin
            scaled_in = mul_out;
            state_in  = SOC_RUN;
         end
         SOC_RUN: begin
            if (cap_ff == '0) begin
               state_in = PT_START;
            end else begin
               div_start_in       = 1'b1;
               div_req_in.rem     = scaled_ff[PROD_W-1:SOC_W];
               div_req_in.num     = {scaled_ff[SOC_W-1:0], {STORE_W{1'b0}}};
               div_req_in.steps   = SOC_STEPS;
               div_req_in.divisor = cap_ff;
               state_in           = SOC_WAIT;
            end
         end
         SOC_WAIT: begin
            if (div_sts.done) begin
               soc_in   = div_sts.quotient[SOC_W-1:0];
               state_in = PT_START;
            end
         end
         PT_START: begin
            cnt_in = '0;
            if (cur_ff == '0 || n_sat == '0) begin
               state_in = FINISH;
            end else begin
               state_in = PT_MUL;
            end
         end
         PT_MUL: begin
            prod_in  = mul_out;
            state_in = PT_CMP;
         end
         PT_CMP: begin
            if (hit) begin
               best_in  = prod_ff;
               found_in = 1'b1;
            end
            if (cnt_ff + 1'b1 == n_sat) begin
               state_in = TIME_RUN;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = PT_MUL;
            end
         end
         TIME_RUN: begin
            if (found_ff) begin
               div_start_in       = 1'b1;
               div_req_in.rem     = '0;
               div_req_in.num     = diff;
               div_req_in.steps   = TIME_STEPS;
               div_req_in.divisor = cur_x10;
               state_in           = TIME_WAIT;
            end else begin
               state_in = FINISH;
            end
         end
         TIME_WAIT: begin
            if (div_sts.done) begin
               ms_in    = div_sts.quotient[MS_W-1:0];
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_charge_in = store_ff;
               rsp_soc_in    = soc_ff;
               rsp_ms_in     = ms_ff;
               rsp_nl_in     = !found_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         store_ff     <= '0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         store_ff     <= store_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      scaled_ff     <= scaled_in;
      prod_ff       <= prod_in;
      best_ff       <= best_in;
      soc_ff        <= soc_in;
      ms_ff         <= ms_in;
      div_req_ff    <= div_req_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_soc_ff    <= rsp_soc_in;
      rsp_ms_ff     <= rsp_ms_in;
      rsp_nl_ff     <= rsp_nl_in;
   end

   ccbt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .req   (div_req_ff),
      .sts   (div_sts)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.stored_charge    = rsp_charge_ff;
   assign rsp_bus.soc_hundredths   = rsp_soc_ff;
   assign rsp_bus.time_to_point_ms = rsp_ms_ff;
   assign rsp_bus.no_limit         = rsp_nl_ff;

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == SOC_WAIT || state_ff == TIME_WAIT))
      else $error("divider finished outside a wait state");

   a_store_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == SCALE |-> store_ff <= cap_ff)
      else $error("stored charge above capacity");

   a_no_limit_zero_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nl_ff) |-> rsp_ms_ff == '0)
      else $error("time nonzero with no breakpoint");

   a_time_needs_point: assert property (@(posedge clock) disable iff (reset)
      state_ff == TIME_WAIT |-> (found_ff && cur_ff != '0))
      else $error("time division without breakpoint or current");

endmodule
